// ===== hw/rtl/plfc_pkg.sv =====
// ----------------------------------------------------------------------------
// PMBus linear format converter package
// Shared widths, command and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package plfc_pkg;

  localparam int CMD_W      = 3;
  localparam int VALUE_W    = 42;
  localparam int CODE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int VOUT_EXP_W = 5;
  localparam int MANT_W     = 11;
  localparam int EXP_STEPS  = 16;

  localparam logic [VOUT_EXP_W-1:0] VOUT_EXP_RESET = 5'h17;
  localparam logic [CODE_W-1:0]     CODE_SAT       = 16'hFFFF;
  localparam logic [1:0]            ADDR_VOUT_EXP  = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_DEC11_INT   = 3'd0,
    CMD_DEC11_EXACT = 3'd1,
    CMD_ENC11_INT   = 3'd2,
    CMD_ENC11_FRAC  = 3'd3,
    CMD_DEC16       = 3'd4,
    CMD_ENC16       = 3'd5
  } plfc_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SIGN = 2'd1,
    STATUS_NO_EXP   = 2'd2,
    STATUS_SAT      = 2'd3
  } plfc_status_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value_in;
    logic [CODE_W-1:0]  code_in;
  } plfc_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic [CODE_W-1:0]  code_out;
    plfc_status_t       status;
  } plfc_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plfc_if.sv =====
// ----------------------------------------------------------------------------
// PMBus linear format converter channels
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface plfc_req_if;
  logic                                valid;
  logic                                ready;
  logic [plfc_pkg::CMD_W-1:0]          command;
  logic signed [plfc_pkg::VALUE_W-1:0] value_in;
  logic [plfc_pkg::CODE_W-1:0]         code_in;

  modport source (output valid, command, value_in, code_in, input ready);
  modport sink   (input valid, command, value_in, code_in, output ready);
endinterface

interface plfc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [plfc_pkg::VALUE_W-1:0] value_out;
  logic [plfc_pkg::CODE_W-1:0]         code_out;
  logic [plfc_pkg::STATUS_W-1:0]       status;

  modport source (output valid, value_out, code_out, status, input ready);
  modport sink   (input valid, value_out, code_out, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plfc_convert.sv =====
// ----------------------------------------------------------------------------
// PMBus linear format converter datapath
// One LINEAR11 / ULINEAR16 conversion per transaction, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module plfc_convert #(
  parameter int FRACTION_BITS = 16
) (
  input  var plfc_pkg::plfc_item_t              item,
  input  var logic [plfc_pkg::VOUT_EXP_W-1:0]   vout_exponent,
  output plfc_pkg::plfc_result_t                res
);

  localparam int VALUE_W = plfc_pkg::VALUE_W;
  localparam int CODE_W  = plfc_pkg::CODE_W;
  localparam int MANT_W  = plfc_pkg::MANT_W;
  localparam int STEPS   = plfc_pkg::EXP_STEPS;
  localparam int MAG_W   = FRACTION_BITS + 31;
  localparam int SH_W    = $clog2(FRACTION_BITS + 16);
  localparam int INT_W   = VALUE_W - FRACTION_BITS;

  logic signed [4:0]       e;
  logic [4:0]              neg_e;
  logic                    mneg;
  logic [MANT_W-1:0]       mmag;
  logic [SH_W-1:0]         sh1;
  logic [SH_W-1:0]         sh4;
  logic [MAG_W-1:0]        n0;
  logic [MAG_W-1:0]        mag0;
  logic [MAG_W-1:0]        mag1;
  logic [MAG_W-1:0]        mag4;
  logic [MAG_W-1:0]        dec_mag;
  logic                    dec_neg;
  logic                    dec_ovf;
  logic [VALUE_W-1:0]      dec_val;
  logic [VALUE_W-1:0]      vu;
  logic                    vneg;
  logic [INT_W-1:0]        n2;
  logic [STEPS-1:0]        fit2;
  logic [3:0]              sel2;
  logic [VALUE_W-1:0]      mant2;
  logic [STEPS-1:0]        fit3;
  logic [STEPS-1:0]        big3;
  logic [MANT_W-2:0]       mant3 [STEPS];
  logic [3:0]              sel3;
  logic [VALUE_W-1:0]      q5;

  assign e     = $signed(item.code_in[15:11]);
  assign neg_e = 5'(-e);
  assign mneg  = item.code_in[10];
  assign mmag  = mneg ? MANT_W'(12'd2048 - {1'b0, item.code_in[10:0]}) : item.code_in[10:0];
  assign sh1   = SH_W'(e + FRACTION_BITS);
  assign sh4   = SH_W'($signed(vout_exponent) + FRACTION_BITS);

  assign n0   = e[4] ? (MAG_W'(mmag) >> neg_e) : (MAG_W'(mmag) << e[3:0]);
  assign mag0 = n0 << FRACTION_BITS;
  assign mag1 = MAG_W'(mmag) << sh1;
  assign mag4 = MAG_W'(item.code_in) << sh4;

  assign vu   = item.value_in;
  assign vneg = vu[VALUE_W-1];
  assign n2   = vu[VALUE_W-1:FRACTION_BITS];
  assign q5   = vu >> sh4;

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      fit2[i]  = (n2 >> (i + 10)) == '0;
      fit3[i]  = (vu >> (FRACTION_BITS + 10 - i)) != '0;
      big3[i]  = (vu >> (FRACTION_BITS + 11 - i)) != '0;
      mant3[i] = (MANT_W-1)'(vu >> (FRACTION_BITS + 1 - i));
    end
    sel2 = '0;
    sel3 = '0;
    for (int i = STEPS - 1; i >= 0; i--) begin
      if (fit2[i]) begin
        sel2 = 4'(i);
      end
      if (fit3[i]) begin
        sel3 = 4'(i);
      end
    end
  end

  assign mant2 = VALUE_W'(n2) >> sel2;

  always_comb begin
    unique case (item.command)
      plfc_pkg::CMD_DEC11_INT: begin
        dec_mag = mag0;
        dec_neg = mneg;
      end
      plfc_pkg::CMD_DEC11_EXACT: begin
        dec_mag = mag1;
        dec_neg = mneg;
      end
      plfc_pkg::CMD_DEC16: begin
        dec_mag = mag4;
        dec_neg = 1'b0;
      end
      default: begin
        dec_mag = '0;
        dec_neg = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (dec_neg) begin
      dec_ovf = (|dec_mag[MAG_W-1:VALUE_W]) ||
                (dec_mag[VALUE_W-1] && (|dec_mag[VALUE_W-2:0]));
      dec_val = dec_ovf ? {1'b1, {(VALUE_W-1){1'b0}}} : VALUE_W'(-dec_mag[VALUE_W-1:0]);
    end else begin
      dec_ovf = |dec_mag[MAG_W-1:VALUE_W-1];
      dec_val = dec_ovf ? {1'b0, {(VALUE_W-1){1'b1}}} : dec_mag[VALUE_W-1:0];
    end
  end

  always_comb begin
    res.value_out = '0;
    res.code_out  = '0;
    res.status    = plfc_pkg::STATUS_OK;
    unique case (item.command)
      plfc_pkg::CMD_DEC11_INT, plfc_pkg::CMD_DEC11_EXACT, plfc_pkg::CMD_DEC16: begin
        res.value_out = dec_val;
        if (dec_ovf) begin
          res.status = plfc_pkg::STATUS_SAT;
        end
      end
      plfc_pkg::CMD_ENC11_INT: begin
        if (vneg) begin
          res.status = plfc_pkg::STATUS_BAD_SIGN;
        end else if (fit2 == '0) begin
          res.status = plfc_pkg::STATUS_NO_EXP;
        end else begin
          res.code_out = {1'b0, sel2, MANT_W'(mant2)};
        end
      end
      plfc_pkg::CMD_ENC11_FRAC: begin
        if (vneg || vu == '0) begin
          res.status = plfc_pkg::STATUS_BAD_SIGN;
        end else if (fit3 == '0 || big3[sel3]) begin
          res.status = plfc_pkg::STATUS_NO_EXP;
        end else begin
          res.code_out = {5'(5'd1 - {1'b0, sel3}), 1'b0, mant3[sel3]};
        end
      end
      plfc_pkg::CMD_ENC16: begin
        if (vneg) begin
          res.status = plfc_pkg::STATUS_BAD_SIGN;
        end else if (|q5[VALUE_W-1:CODE_W]) begin
          res.code_out = plfc_pkg::CODE_SAT;
          res.status   = plfc_pkg::STATUS_SAT;
        end else begin
          res.code_out = q5[CODE_W-1:0];
        end
      end
      default: begin
        res.status = plfc_pkg::STATUS_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pmbus_linear_format_converter_top.sv =====
// Result path: the request transaction loads the input register, and the
// conversion of it loads the result register, which drives result.valid.
// Throughput: 1 transaction per cycle unless result stalls; the input and
// result registers each advance whenever the stage after them is free.
// Reset (rst, synchronous, active high) empties both registers and sets
// vout_exponent to -9.
// ----------------------------------------------------------------------------
// PMBus linear format converter
// Two-register pipeline around the conversion datapath, with an APB-style
// write/read port for vout_exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module pmbus_linear_format_converter_top #(
  parameter int FRACTION_BITS = 16
) (
  input  var logic                  clk,
  input  var logic                  rst,
  plfc_req_if.sink                  request,
  plfc_res_if.source                result,
  input  var logic                  psel,
  input  var logic                  penable,
  input  var logic                  pwrite,
  input  var logic [1:0]            paddr,
  input  var logic [31:0]           pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic                                   stage_valid;
  plfc_pkg::plfc_item_t                   stage_item;
  logic                                   res_valid;
  plfc_pkg::plfc_result_t                 res_data;
  plfc_pkg::plfc_result_t                 conv_res;
  logic [plfc_pkg::VOUT_EXP_W-1:0]        vout_exponent;
  logic                                   out_free;
  logic                                   cfg_write;

  assign out_free      = !res_valid || result.ready;
  assign request.ready = !stage_valid || out_free;
  assign cfg_write     = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr == plfc_pkg::ADDR_VOUT_EXP)
                ? {{(32-plfc_pkg::VOUT_EXP_W){1'b0}}, vout_exponent} : '0;

  plfc_convert #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_convert (
    .item          (stage_item),
    .vout_exponent (vout_exponent),
    .res           (conv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      res_valid     <= 1'b0;
      vout_exponent <= plfc_pkg::VOUT_EXP_RESET;
    end else begin
      if (request.ready) begin
        stage_valid <= request.valid;
      end
      if (out_free) begin
        res_valid <= stage_valid;
      end
      if (cfg_write) begin
        vout_exponent <= pwdata[plfc_pkg::VOUT_EXP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      stage_item.command  <= request.command;
      stage_item.value_in <= request.value_in;
      stage_item.code_in  <= request.code_in;
    end
    if (stage_valid && out_free) begin
      res_data <= conv_res;
    end
  end

  assign result.valid     = res_valid;
  assign result.value_out = $signed(res_data.value_out);
  assign result.code_out  = res_data.code_out;
  assign result.status    = res_data.status;

endmodule

`default_nettype wire

// ===== hw/rtl/plfc_checker.sv =====
// ----------------------------------------------------------------------------
// PMBus linear format converter checker
// Port-level assertions on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plfc_checker (
  input var logic                               clk,
  input var logic                               rst,
  input var logic                               req_valid,
  input var logic                               req_ready,
  input var logic                               res_valid,
  input var logic                               res_ready,
  input var logic [plfc_pkg::VALUE_W-1:0]       value_out,
  input var logic [plfc_pkg::CODE_W-1:0]        code_out,
  input var logic [plfc_pkg::STATUS_W-1:0]      status
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(value_out) && $stable(code_out)
      && $stable(status))
    else $error("stalled result changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready ##1 res_ready |=> res_valid)
    else $error("result missing two cycles after transaction");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == plfc_pkg::STATUS_BAD_SIGN || status == plfc_pkg::STATUS_NO_EXP)
      |-> code_out == '0 && value_out == '0)
    else $error("error result carries data");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == plfc_pkg::STATUS_SAT
      |-> value_out != '0 || code_out == plfc_pkg::CODE_SAT)
    else $error("saturated result without limit value");

endmodule

bind pmbus_linear_format_converter_top plfc_checker u_plfc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .value_out (result.value_out),
  .code_out  (result.code_out),
  .status    (result.status)
);

`default_nettype wire

// ===== verif/pmbus_linear_format_converter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PMBus linear format converter testbench
// Drives LINEAR11 and ULINEAR16 conversions through the request channel and
// checks every result against a directed row's expected values or an in-bench
// conversion model. Outside the last phase both channels idle and stall in
// random bursts; vout_exponent is swept over several settings between phases.
// ----------------------------------------------------------------------------

module pmbus_linear_format_converter_top_tb;

  localparam int          FRACTION_BITS  = 16;
  localparam int          HALF_PERIOD    = 4;
  localparam int          RESET_CYCLES   = 11;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_ITEMS    = 80;
  localparam int          MAX_GAP        = 13;
  localparam logic [2:0]  CMD_UNUSED_6   = 3'd6;
  localparam logic [2:0]  CMD_UNUSED_7   = 3'd7;
  localparam logic [63:0] MANT_LIMIT     = 64'd1024;
  localparam logic [63:0] FIXED_MAX      = 64'h1FF_FFFF_FFFF;
  localparam logic [63:0] FIXED_NEG_LIM  = 64'h200_0000_0000;
  localparam logic [63:0] EXP_FIELD_MASK = 64'hF800;
  localparam int          EXP_MASK       = 'h1F;
  localparam int          MAX_EXP_STEP   = 15;

  typedef struct {
    logic [plfc_pkg::CMD_W-1:0]   command;
    logic [plfc_pkg::VALUE_W-1:0] value_in;
    logic [plfc_pkg::CODE_W-1:0]  code_in;
    bit                           typed;
    logic [plfc_pkg::VALUE_W-1:0] want_value;
    logic [plfc_pkg::CODE_W-1:0]  want_code;
    plfc_pkg::plfc_status_t       want_status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{plfc_pkg::CMD_DEC11_INT,   42'h0,           16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_INT,   42'h0,           16'h7BFF,
      1'b1, 42'h1FF80000000, 16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_INT,   42'h0,           16'h7C00,
      1'b1, 42'h20000000000, 16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_INT,   42'h0,           16'h8401,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_INT,   42'h0,           16'hF3FF,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_INT,   42'h0,           16'hF7FF,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_EXACT, 42'h0,           16'h03FF,
      1'b1, 42'h3FF0000,     16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_EXACT, 42'h0,           16'h8400,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_EXACT, 42'h0,           16'h7C00,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC11_EXACT, 42'h0,           16'hFFFF,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC11_INT,   42'h0,           16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC11_INT,   42'h20000000000, 16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_BAD_SIGN},
    '{plfc_pkg::CMD_ENC11_INT,   42'h1FFFFFFFFFF, 16'h0000,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC11_INT,   42'h4000000,     16'h0000,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC11_FRAC,  42'h0,           16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_BAD_SIGN},
    '{plfc_pkg::CMD_ENC11_FRAC,  42'h3FFFFFFFFFF, 16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_BAD_SIGN},
    '{plfc_pkg::CMD_ENC11_FRAC,  42'h1,           16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_NO_EXP},
    '{plfc_pkg::CMD_ENC11_FRAC,  42'h8000000,     16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_NO_EXP},
    '{plfc_pkg::CMD_ENC11_FRAC,  42'h800,         16'h0000,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC11_FRAC,  42'h7FFFFFF,     16'h0000,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_DEC16,       42'h0,           16'hFFFF,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC16,       42'h1FFFFFFFFFF, 16'h0000,
      1'b0, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{plfc_pkg::CMD_ENC16,       42'h3FFFFFFFFFF, 16'h0000,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_BAD_SIGN},
    '{CMD_UNUSED_6,              42'h3FFFFFFFFFF, 16'hFFFF,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_OK},
    '{CMD_UNUSED_7,              42'h3FFFFFFFFFF, 16'hFFFF,
      1'b1, 42'h0,           16'h0, plfc_pkg::STATUS_OK}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  plfc_req_if req_ch ();
  plfc_res_if res_ch ();

  pmbus_linear_format_converter_top #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(req_ch),
    .result (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  plfc_pkg::plfc_result_t          pending_conversions [$];
  logic [plfc_pkg::VOUT_EXP_W-1:0] vout_exp_setting;
  bit                              idling_on;
  int                              mismatch_count;
  int                              stall_cycles;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic logic [63:0] shift_mag(logic [63:0] mag, int sh);
    if (sh >= 0) return (sh < 64) ? (mag << sh) : 64'd0;
    return (-sh < 64) ? (mag >> (-sh)) : 64'd0;
  endfunction

  function automatic logic [plfc_pkg::VALUE_W-1:0] to_fixed(bit neg, logic [63:0] mag,
                                                            inout plfc_pkg::plfc_status_t st);
    logic [63:0] twos;
    if (!neg) begin
      if (mag > FIXED_MAX) begin
        st  = plfc_pkg::STATUS_SAT;
        mag = FIXED_MAX;
      end
      return mag[plfc_pkg::VALUE_W-1:0];
    end
    if (mag > FIXED_NEG_LIM) begin
      st  = plfc_pkg::STATUS_SAT;
      mag = FIXED_NEG_LIM;
    end
    twos = -mag;
    return twos[plfc_pkg::VALUE_W-1:0];
  endfunction

  function automatic plfc_pkg::plfc_result_t predict_conversion(
      logic [plfc_pkg::CMD_W-1:0]      cmd,
      logic [plfc_pkg::VALUE_W-1:0]    v,
      logic [plfc_pkg::CODE_W-1:0]     word,
      logic [plfc_pkg::VOUT_EXP_W-1:0] vexp);
    plfc_pkg::plfc_result_t       r;
    plfc_pkg::plfc_status_t       st;
    logic [plfc_pkg::VALUE_W-1:0] value;
    logic [63:0]                  code;
    logic [63:0]                  v64;
    logic [63:0]                  mmag;
    logic [63:0]                  n;
    logic [63:0]                  m;
    logic [10:0]                  m11;
    bit                           mneg;
    int                           e;
    int                           ve;
    int                           i;
    int                           k;
    st    = plfc_pkg::STATUS_OK;
    value = '0;
    code  = '0;
    v64   = {{(64 - plfc_pkg::VALUE_W){1'b0}}, v};
    e     = $signed(word[15:11]);
    ve    = $signed(vexp);
    m11   = word[10:0];
    mneg  = m11[10];
    mmag  = mneg ? (64'd2048 - m11) : {53'd0, m11};
    case (cmd)
      plfc_pkg::CMD_DEC11_INT: begin
        n     = shift_mag(mmag, e);
        value = to_fixed(mneg, shift_mag(n, FRACTION_BITS), st);
      end
      plfc_pkg::CMD_DEC11_EXACT: begin
        value = to_fixed(mneg, shift_mag(mmag, e + FRACTION_BITS), st);
      end
      plfc_pkg::CMD_ENC11_INT: begin
        if (v[plfc_pkg::VALUE_W-1]) begin
          st = plfc_pkg::STATUS_BAD_SIGN;
        end else begin
          n = v64 >> FRACTION_BITS;
          for (i = 0; i <= MAX_EXP_STEP && (n >> i) >= MANT_LIMIT; i++) ;
          if (i > MAX_EXP_STEP) st = plfc_pkg::STATUS_NO_EXP;
          else code = ((i << 11) & EXP_FIELD_MASK) + (n >> i);
        end
      end
      plfc_pkg::CMD_ENC11_FRAC: begin
        if (v[plfc_pkg::VALUE_W-1] || v == '0) begin
          st = plfc_pkg::STATUS_BAD_SIGN;
        end else begin
          for (i = 0; i <= MAX_EXP_STEP && shift_mag(v64, i - FRACTION_BITS) < MANT_LIMIT;
               i++) ;
          if (i > MAX_EXP_STEP) begin
            st = plfc_pkg::STATUS_NO_EXP;
          end else begin
            k = i - 1;
            m = shift_mag(v64, k - FRACTION_BITS);
            if (m >= MANT_LIMIT) st = plfc_pkg::STATUS_NO_EXP;
            else code = (64'((-k) & EXP_MASK) << 11) + m;
          end
        end
      end
      plfc_pkg::CMD_DEC16: begin
        value = to_fixed(1'b0, shift_mag({48'd0, word}, ve + FRACTION_BITS), st);
      end
      plfc_pkg::CMD_ENC16: begin
        if (v[plfc_pkg::VALUE_W-1]) begin
          st = plfc_pkg::STATUS_BAD_SIGN;
        end else begin
          code = shift_mag(v64, -(ve + FRACTION_BITS));
          if (code > {48'd0, plfc_pkg::CODE_SAT}) begin
            code = {48'd0, plfc_pkg::CODE_SAT};
            st   = plfc_pkg::STATUS_SAT;
          end
        end
      end
      default: ;
    endcase
    r.value_out = value;
    r.code_out  = code[plfc_pkg::CODE_W-1:0];
    r.status    = st;
    return r;
  endfunction

  function automatic plfc_pkg::plfc_item_t next_random_item();
    plfc_pkg::plfc_item_t         it;
    logic [63:0]                  raw;
    logic [plfc_pkg::VALUE_W-1:0] mag;
    raw = {$urandom, $urandom};
    mag = raw[plfc_pkg::VALUE_W-1:0];
    it.command = ($urandom_range(0, 49) == 0) ? plfc_pkg::CMD_W'($urandom_range(6, 7))
                                              : plfc_pkg::CMD_W'($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0: it.value_in = mag;
      1: it.value_in = mag >> $urandom_range(1, plfc_pkg::VALUE_W - 1);
      2: it.value_in = -(mag >> $urandom_range(1, plfc_pkg::VALUE_W - 1));
      default: it.value_in = mag >> $urandom_range(10, 28);
    endcase
    it.code_in = plfc_pkg::CODE_W'($urandom);
    case ($urandom_range(0, 5))
      0: it.code_in[15:11] = 5'h0F;
      1: it.code_in[15:11] = 5'h10;
      default: ;
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_item(plfc_pkg::plfc_item_t it, bit typed,
                           plfc_pkg::plfc_result_t typed_res);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, MAX_GAP);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.command  <= it.command;
    req_ch.value_in <= it.value_in;
    req_ch.code_in  <= it.code_in;
    do @(posedge clk); while (!req_ch.ready);
    pending_conversions.push_back(typed ? typed_res
        : predict_conversion(it.command, it.value_in, it.code_in, vout_exp_setting));
  endtask

  task automatic release_request();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= plfc_pkg::ADDR_VOUT_EXP;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_vout_exp();
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[plfc_pkg::VOUT_EXP_W-1:0] !== vout_exp_setting)
      report_mismatch($sformatf("vout_exponent read %h, want %h",
                                rdata[plfc_pkg::VOUT_EXP_W-1:0], vout_exp_setting));
  endtask

  task automatic write_vout_exp(logic [plfc_pkg::VOUT_EXP_W-1:0] e);
    logic [31:0] rdata;
    apb_access(1'b1, {{(32 - plfc_pkg::VOUT_EXP_W){e[plfc_pkg::VOUT_EXP_W-1]}}, e}, rdata);
    vout_exp_setting = e;
    check_vout_exp();
  endtask

  initial begin : result_ready_driver
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && !rst && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, MAX_GAP);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    plfc_pkg::plfc_result_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_conversions.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h code %h status %0d",
                                    res_ch.value_out, res_ch.code_out, res_ch.status));
        end else begin
          want = pending_conversions.pop_front();
          if (res_ch.value_out !== want.value_out)
            report_mismatch($sformatf("value_out %h, want %h",
                                      res_ch.value_out, want.value_out));
          if (res_ch.code_out !== want.code_out)
            report_mismatch($sformatf("code_out %h, want %h",
                                      res_ch.code_out, want.code_out));
          if (res_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      res_ch.status, want.status));
        end
      end
      if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [plfc_pkg::VOUT_EXP_W-1:0] phase_exps [5];
    plfc_pkg::plfc_item_t            it;
    plfc_pkg::plfc_result_t          typed_res;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.command   = '0;
    req_ch.value_in  = '0;
    req_ch.code_in   = '0;
    mismatch_count   = 0;
    idling_on        = 1'b1;
    vout_exp_setting = plfc_pkg::VOUT_EXP_RESET;
    phase_exps       = '{5'h10, 5'h0F, 5'h00, 5'h00, plfc_pkg::VOUT_EXP_RESET};
    phase_exps[3]    = plfc_pkg::VOUT_EXP_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_vout_exp();
    foreach (directed_rows[r]) begin
      it.command            = directed_rows[r].command;
      it.value_in           = directed_rows[r].value_in;
      it.code_in            = directed_rows[r].code_in;
      typed_res.value_out   = directed_rows[r].want_value;
      typed_res.code_out    = directed_rows[r].want_code;
      typed_res.status      = directed_rows[r].want_status;
      send_item(it, directed_rows[r].typed, typed_res);
    end
    for (int n = 0; n < PHASE_ITEMS; n++) send_item(next_random_item(), 1'b0, typed_res);
    release_request();
    drain_results();

    foreach (phase_exps[p]) begin
      if (p == $size(phase_exps) - 1) idling_on = 1'b0;
      write_vout_exp(phase_exps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(next_random_item(), 1'b0, typed_res);
      release_request();
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/plfc_pkg.sv
hw/rtl/plfc_if.sv
hw/rtl/plfc_convert.sv
hw/rtl/pmbus_linear_format_converter_top.sv
hw/rtl/plfc_checker.sv
verif/pmbus_linear_format_converter_top_tb.sv
